[design/jsam_pkg.sv]
`default_nettype none
package jsam_pkg;

	localparam int AXIS_W = 8;
	localparam int STEP_W = 7;
	localparam int GAIN_W = 8;
	localparam int LEVEL_W = 15;
	localparam int CURVE_IDX_W = 7;
	localparam int CURVE_N = 128;
	localparam int CURVE_DIV = 127;
	localparam int CURVE_SCALE = 256;
	localparam int FRAC_W = 8;
	localparam int PROD_W = LEVEL_W + GAIN_W;
	localparam int TERM_W = PROD_W + 1;
	localparam int SUM_W = TERM_W + 1;
	localparam int MIX_SHIFT = 16;
	localparam int QUOT_W = SUM_W - MIX_SHIFT;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 8;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(32512);
	localparam logic signed [AXIS_W-1:0] DRIVE_MAX = 8'sd127;
	localparam logic signed [AXIS_W-1:0] DRIVE_MIN = -8'sd127;

	localparam logic [STEP_W-1:0] RISE_STEP_RESET = 7'd50;
	localparam logic [STEP_W-1:0] FALL_STEP_RESET = 7'd50;
	localparam logic [GAIN_W-1:0] TURN_GAIN_RESET = 8'd179;
	localparam logic REVERSE_MIX_RESET = 1'b0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_RISE_STEP   = 8'd0,
		CFG_FALL_STEP   = 8'd1,
		CFG_TURN_GAIN   = 8'd2,
		CFG_REVERSE_MIX = 8'd3
	} cfg_index_t;

	typedef struct packed {
		logic [STEP_W-1:0] rise_step;
		logic [STEP_W-1:0] fall_step;
		logic [GAIN_W-1:0] turn_gain;
		logic reverse_mix;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] forward_level;
		logic [LEVEL_W-1:0] turn_level;
		logic fwd_neg;
		logic fwd_zero;
		logic turn_neg;
		logic turn_zero;
	} shaped_t;

	typedef logic [LEVEL_W-1:0] goal_t;
	typedef goal_t [CURVE_N-1:0] goal_table_t;

	function automatic goal_table_t make_goal_table();
		goal_table_t t;
		for (int i = 0; i < CURVE_N; i++) begin
			t[i] = LEVEL_W'((i * i * CURVE_SCALE) / CURVE_DIV);
		end
		return t;
	endfunction

	localparam goal_table_t GOAL_TABLE = make_goal_table();

endpackage
`default_nettype wire

[design/jsam_if.sv]
`default_nettype none
interface jsam_in_if;
	logic valid;
	logic ready;
	logic signed [7:0] forward_axis;
	logic signed [7:0] left_turn_axis;
	logic signed [7:0] right_turn_axis;
	modport source(output valid, forward_axis, left_turn_axis, right_turn_axis, input ready);
	modport sink(input valid, forward_axis, left_turn_axis, right_turn_axis, output ready);
endinterface

interface jsam_out_if;
	logic valid;
	logic ready;
	logic signed [7:0] left_drive;
	logic signed [7:0] right_drive;
	modport source(output valid, left_drive, right_drive, input ready);
	modport sink(input valid, left_drive, right_drive, output ready);
endinterface

interface jsam_cfg_if;
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/jsam_shape.sv]
`default_nettype none
module jsam_shape
	import jsam_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic capture,
	input  wire logic advance,
	input  wire logic signed [AXIS_W-1:0] forward_axis,
	input  wire logic signed [AXIS_W-1:0] left_turn_axis,
	input  wire logic signed [AXIS_W-1:0] right_turn_axis,
	input  wire logic [STEP_W-1:0] rise_step,
	input  wire logic [STEP_W-1:0] fall_step,
	output shaped_t shaped
);

	logic signed [AXIS_W-1:0] fwd_s1;
	logic signed [AXIS_W-1:0] lx_s1;
	logic signed [AXIS_W-1:0] rx_s1;
	logic [LEVEL_W-1:0] forward_level_q;
	logic [LEVEL_W-1:0] turn_level_q;
	logic fwd_neg_q;
	logic fwd_zero_q;
	logic turn_neg_q;
	logic turn_zero_q;

	logic [AXIS_W-1:0] fwd_mag;
	logic [AXIS_W-1:0] lx_mag;
	logic [AXIS_W-1:0] rx_mag;
	logic signed [AXIS_W-1:0] turn_axis;
	logic [AXIS_W-1:0] turn_mag;
	logic [LEVEL_W-1:0] fwd_goal;
	logic [LEVEL_W-1:0] turn_goal;
	logic [LEVEL_W-1:0] up_step;
	logic [LEVEL_W-1:0] drop_step;
	logic [LEVEL_W-1:0] fwd_next;
	logic [LEVEL_W-1:0] turn_next;

	function automatic logic [AXIS_W-1:0] mag_of(input logic signed [AXIS_W-1:0] v);
		return v[AXIS_W-1] ? AXIS_W'(-v) : AXIS_W'(v);
	endfunction

	function automatic logic [CURVE_IDX_W-1:0] curve_index(input logic [AXIS_W-1:0] m);
		return m[AXIS_W-1] ? {CURVE_IDX_W{1'b1}} : m[CURVE_IDX_W-1:0];
	endfunction

	function automatic logic [LEVEL_W-1:0] slew(
		input logic [LEVEL_W-1:0] level,
		input logic [LEVEL_W-1:0] goal,
		input logic [LEVEL_W-1:0] up,
		input logic [LEVEL_W-1:0] down
	);
		logic [LEVEL_W-1:0] d;
		if (goal >= level) begin
			d = goal - level;
			return (d < up) ? goal : LEVEL_W'(level + up);
		end else begin
			d = level - goal;
			return (d < down) ? goal : LEVEL_W'(level - down);
		end
	endfunction

	always_ff @(posedge clk) begin
		if (capture) begin
			fwd_s1 <= forward_axis;
			lx_s1 <= left_turn_axis;
			rx_s1 <= right_turn_axis;
		end
	end

	always_comb begin
		fwd_mag = mag_of(fwd_s1);
		lx_mag = mag_of(lx_s1);
		rx_mag = mag_of(rx_s1);
		turn_axis = (rx_mag < lx_mag) ? lx_s1 : rx_s1;
		turn_mag = (rx_mag < lx_mag) ? lx_mag : rx_mag;
		fwd_goal = GOAL_TABLE[curve_index(fwd_mag)];
		turn_goal = GOAL_TABLE[curve_index(turn_mag)];
		up_step = {rise_step, FRAC_W'(0)};
		drop_step = {fall_step, FRAC_W'(0)};
		fwd_next = slew(forward_level_q, fwd_goal, up_step, drop_step);
		turn_next = slew(turn_level_q, turn_goal, up_step, drop_step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_level_q <= '0;
			turn_level_q <= '0;
		end else if (advance) begin
			forward_level_q <= fwd_next;
			turn_level_q <= turn_next;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_neg_q <= fwd_s1[AXIS_W-1];
			fwd_zero_q <= (fwd_s1 == '0);
			turn_neg_q <= turn_axis[AXIS_W-1];
			turn_zero_q <= (turn_axis == '0);
		end
	end

	assign shaped.forward_level = forward_level_q;
	assign shaped.turn_level = turn_level_q;
	assign shaped.fwd_neg = fwd_neg_q;
	assign shaped.fwd_zero = fwd_zero_q;
	assign shaped.turn_neg = turn_neg_q;
	assign shaped.turn_zero = turn_zero_q;

endmodule
`default_nettype wire

[design/jsam_mix.sv]
`default_nettype none
module jsam_mix
	import jsam_pkg::*;
(
	input  wire logic clk,
	input  wire logic load_terms,
	input  wire logic load_out,
	input  wire shaped_t shaped,
	input  wire logic [GAIN_W-1:0] turn_gain,
	input  wire logic reverse_mix,
	output logic signed [AXIS_W-1:0] left_drive,
	output logic signed [AXIS_W-1:0] right_drive
);

	logic signed [TERM_W-1:0] f_term_s3;
	logic signed [TERM_W-1:0] t_term_s3;
	logic signed [AXIS_W-1:0] left_q;
	logic signed [AXIS_W-1:0] right_q;

	logic [PROD_W-1:0] f_mag;
	logic [PROD_W-1:0] t_mag;
	logic signed [TERM_W-1:0] f_term;
	logic signed [TERM_W-1:0] t_term;
	logic signed [SUM_W-1:0] sum_plus;
	logic signed [SUM_W-1:0] sum_minus;

	function automatic logic signed [TERM_W-1:0] apply_dir(
		input logic [PROD_W-1:0] m,
		input logic neg,
		input logic zero
	);
		logic signed [TERM_W-1:0] p;
		p = $signed({1'b0, m});
		if (zero) begin
			return '0;
		end else if (neg) begin
			return -p;
		end else begin
			return p;
		end
	endfunction

	function automatic logic signed [AXIS_W-1:0] trunc_sat(input logic signed [SUM_W-1:0] s);
		logic signed [QUOT_W-1:0] q;
		q = QUOT_W'(s >>> MIX_SHIFT);
		if (s[SUM_W-1] && (s[MIX_SHIFT-1:0] != '0)) begin
			q = QUOT_W'(q + QUOT_W'(1));
		end
		if (q > QUOT_W'(DRIVE_MAX)) begin
			return DRIVE_MAX;
		end else if (q < QUOT_W'(DRIVE_MIN)) begin
			return DRIVE_MIN;
		end else begin
			return AXIS_W'(q);
		end
	endfunction

	always_comb begin
		f_mag = PROD_W'({shaped.forward_level, FRAC_W'(0)});
		t_mag = PROD_W'(shaped.turn_level * turn_gain);
		f_term = apply_dir(f_mag, shaped.fwd_neg, shaped.fwd_zero);
		t_term = apply_dir(t_mag, shaped.turn_neg, shaped.turn_zero);
	end

	always_ff @(posedge clk) begin
		if (load_terms) begin
			f_term_s3 <= f_term;
			t_term_s3 <= t_term;
		end
	end

	always_comb begin
		sum_plus = SUM_W'(f_term_s3) + SUM_W'(t_term_s3);
		sum_minus = SUM_W'(f_term_s3) - SUM_W'(t_term_s3);
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			left_q <= trunc_sat(reverse_mix ? sum_minus : sum_plus);
			right_q <= trunc_sat(reverse_mix ? sum_plus : sum_minus);
		end
	end

	assign left_drive = left_q;
	assign right_drive = right_q;

endmodule
`default_nettype wire

[design/joystick_slew_arcade_mixer.sv]
// Arcade drive mixer with slew-limited, squared stick response. One stick sample
// may be transferred in every clock cycle while the output is not stalled; its
// left and right drive commands pass through the input, level, term and output
// registers in that order before they appear on the output. The forward and
// turn levels are updated once as each sample leaves the input register, so
// back-to-back samples slew exactly one step apart. Configuration writes are
// always accepted and should be made only while no sample is in flight.
`default_nettype none
module joystick_slew_arcade_mixer
	import jsam_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	jsam_in_if.sink drive_in,
	jsam_out_if.source drive_out,
	jsam_cfg_if.sink cfg
);

	cfg_t cfg_q;
	shaped_t shaped;
	logic v_s1_q;
	logic v_s2_q;
	logic v_s3_q;
	logic out_v_q;
	logic adv_out;
	logic adv_s3;
	logic adv_s2;
	logic adv_s1;
	logic in_xfer;

	always_comb begin
		adv_out = !out_v_q || drive_out.ready;
		adv_s3 = !v_s3_q || adv_out;
		adv_s2 = !v_s2_q || adv_s3;
		adv_s1 = !v_s1_q || adv_s2;
		in_xfer = drive_in.valid && adv_s1;
	end

	assign drive_in.ready = adv_s1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rise_step <= RISE_STEP_RESET;
			cfg_q.fall_step <= FALL_STEP_RESET;
			cfg_q.turn_gain <= TURN_GAIN_RESET;
			cfg_q.reverse_mix <= REVERSE_MIX_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RISE_STEP: cfg_q.rise_step <= cfg.data[STEP_W-1:0];
				CFG_FALL_STEP: cfg_q.fall_step <= cfg.data[STEP_W-1:0];
				CFG_TURN_GAIN: cfg_q.turn_gain <= cfg.data[GAIN_W-1:0];
				CFG_REVERSE_MIX: cfg_q.reverse_mix <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1_q <= drive_in.valid;
			end
			if (adv_s2) begin
				v_s2_q <= v_s1_q;
			end
			if (adv_s3) begin
				v_s3_q <= v_s2_q;
			end
			if (adv_out) begin
				out_v_q <= v_s3_q;
			end
		end
	end

	jsam_shape u_shape (
		.clk(clk),
		.arst_n(arst_n),
		.capture(in_xfer),
		.advance(v_s1_q && adv_s2),
		.forward_axis(drive_in.forward_axis),
		.left_turn_axis(drive_in.left_turn_axis),
		.right_turn_axis(drive_in.right_turn_axis),
		.rise_step(cfg_q.rise_step),
		.fall_step(cfg_q.fall_step),
		.shaped(shaped)
	);

	jsam_mix u_mix (
		.clk(clk),
		.load_terms(v_s2_q && adv_s3),
		.load_out(v_s3_q && adv_out),
		.shaped(shaped),
		.turn_gain(cfg_q.turn_gain),
		.reverse_mix(cfg_q.reverse_mix),
		.left_drive(drive_out.left_drive),
		.right_drive(drive_out.right_drive)
	);

	assign drive_out.valid = out_v_q;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		(shaped.forward_level <= LEVEL_MAX) && (shaped.turn_level <= LEVEL_MAX))
		else $error("drive level above full scale");

	a_level_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s1_q && adv_s2) |=> $stable(shaped.forward_level) && $stable(shaped.turn_level))
		else $error("drive level moved without a sample leaving the input register");

	a_out_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (drive_out.left_drive != -8'sd128) && (drive_out.right_drive != -8'sd128))
		else $error("drive command outside the saturated range");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3_q && !out_v_q) |=> out_v_q)
		else $error("result did not advance into an empty output register");

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import jsam_pkg::*;

	typedef struct {
		logic signed [AXIS_W-1:0] left_drive;
		logic signed [AXIS_W-1:0] right_drive;
	} drive_pair_t;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SAMPLES_PER_PHASE = 105;
	localparam int RANDOM_PHASES = 6;
	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 8'd77;

	logic clk;
	logic arst_n;

	jsam_in_if drive_in();
	jsam_out_if drive_out();
	jsam_cfg_if cfg_bus();

	joystick_slew_arcade_mixer dut (
		.clk(clk),
		.arst_n(arst_n),
		.drive_in(drive_in),
		.drive_out(drive_out),
		.cfg(cfg_bus)
	);

	cfg_t shadow_cfg;
	logic [LEVEL_W-1:0] fwd_level;
	logic [LEVEL_W-1:0] turn_level;
	drive_pair_t drive_expected[$];

	int mismatches;
	int results_seen;
	int samples_sent;
	int reg_writes;
	int cycles;
	bit in_gaps_on;
	bit out_stalls_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 96) return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic int axis_mag(input logic signed [AXIS_W-1:0] v);
		return (v < 0) ? -int'(v) : int'(v);
	endfunction

	function automatic int axis_sign(input logic signed [AXIS_W-1:0] v);
		return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
	endfunction

	function automatic logic [LEVEL_W-1:0] curve_goal(input int mag);
		int m;
		m = (mag > 127) ? 127 : mag;
		return LEVEL_W'((m * m * 256) / 127);
	endfunction

	function automatic logic [LEVEL_W-1:0] slew_level(input logic [LEVEL_W-1:0] level,
			input logic [LEVEL_W-1:0] goal);
		int err;
		int up;
		int down;
		int step;
		err = int'(goal) - int'(level);
		up = int'(shadow_cfg.rise_step) * 256;
		down = int'(shadow_cfg.fall_step) * 256;
		if ((err > 0 && err < up) || (err <= 0 && err > -down)) step = err;
		else if (err > 0) step = up;
		else if (err < 0) step = -down;
		else step = 0;
		return LEVEL_W'(int'(level) + step);
	endfunction

	function automatic logic signed [AXIS_W-1:0] clip_drive(input int q16);
		int v;
		v = q16 / 65536;
		if (v > 127) v = 127;
		if (v < -127) v = -127;
		return AXIS_W'(v);
	endfunction

	function automatic logic signed [AXIS_W-1:0] rand_axis();
		case ($urandom_range(0, 7))
			0: return 8'sd127;
			1: return -8'sd127;
			2: return 8'sh80;
			3: return 8'sd0;
			default: return AXIS_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_data(input int lo, input int hi);
		case ($urandom_range(0, 3))
			0: return CFG_DATA_W'(lo);
			1: return CFG_DATA_W'(hi);
			default: return CFG_DATA_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic predict_drive(input logic signed [AXIS_W-1:0] f,
			input logic signed [AXIS_W-1:0] l, input logic signed [AXIS_W-1:0] r);
		logic signed [AXIS_W-1:0] tx;
		int f_term;
		int t_term;
		int left;
		int right;
		drive_pair_t want;
		tx = (axis_mag(r) < axis_mag(l)) ? l : r;
		fwd_level = slew_level(fwd_level, curve_goal(axis_mag(f)));
		turn_level = slew_level(turn_level, curve_goal(axis_mag(tx)));
		f_term = axis_sign(f) * int'(fwd_level) * 256;
		t_term = axis_sign(tx) * int'(turn_level) * int'(shadow_cfg.turn_gain);
		if (!shadow_cfg.reverse_mix) begin
			left = f_term + t_term;
			right = f_term - t_term;
		end else begin
			left = f_term - t_term;
			right = f_term + t_term;
		end
		want.left_drive = clip_drive(left);
		want.right_drive = clip_drive(right);
		drive_expected.push_back(want);
	endtask

	always @(posedge clk) begin
		drive_pair_t want;
		if (arst_n) begin
			if (drive_out.valid && drive_out.ready) begin
				results_seen++;
				if (drive_expected.size() == 0) begin
					mismatches++;
					$error("Unexpected drive transfer: left_drive %0d, right_drive %0d",
						drive_out.left_drive, drive_out.right_drive);
				end else begin
					want = drive_expected.pop_front();
					if (drive_out.left_drive !== want.left_drive) begin
						mismatches++;
						$error("left_drive: expected %0d, actual %0d",
							want.left_drive, drive_out.left_drive);
					end
					if (drive_out.right_drive !== want.right_drive) begin
						mismatches++;
						$error("right_drive: expected %0d, actual %0d",
							want.right_drive, drive_out.right_drive);
					end
				end
			end
			if (drive_in.valid && drive_in.ready) begin
				predict_drive(drive_in.forward_axis, drive_in.left_turn_axis,
					drive_in.right_turn_axis);
			end
			if (cfg_bus.valid && cfg_bus.ready) begin
				reg_writes++;
				case (cfg_bus.index)
					CFG_RISE_STEP: shadow_cfg.rise_step = cfg_bus.data[STEP_W-1:0];
					CFG_FALL_STEP: shadow_cfg.fall_step = cfg_bus.data[STEP_W-1:0];
					CFG_TURN_GAIN: shadow_cfg.turn_gain = cfg_bus.data[GAIN_W-1:0];
					CFG_REVERSE_MIX: shadow_cfg.reverse_mix = cfg_bus.data[0];
					default: ;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else begin
				stall_left = (out_stalls_on && $urandom_range(0, 3) == 0) ? idle_span() : 0;
				drive_out.ready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	task automatic send_sample(input logic signed [AXIS_W-1:0] f,
			input logic signed [AXIS_W-1:0] l, input logic signed [AXIS_W-1:0] r);
		int gap;
		gap = in_gaps_on ? idle_span() : 0;
		if (gap > 0) begin
			drive_in.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		drive_in.valid <= 1'b1;
		drive_in.forward_axis <= f;
		drive_in.left_turn_axis <= l;
		drive_in.right_turn_axis <= r;
		@(posedge clk);
		while (!drive_in.ready) @(posedge clk);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		drive_in.valid <= 1'b0;
		while (drive_expected.size() != 0) @(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data <= value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] rise, input logic [CFG_DATA_W-1:0] fall,
			input logic [CFG_DATA_W-1:0] gain, input logic [CFG_DATA_W-1:0] rev);
		wait_drained();
		write_reg(CFG_RISE_STEP, rise);
		write_reg(CFG_FALL_STEP, fall);
		write_reg(CFG_TURN_GAIN, gain);
		write_reg(CFG_REVERSE_MIX, rev);
	endtask

	// Runs on the reset settings: ramp to full stick, sign flips at full level,
	// turn axis selection on ties and on the -128 code, and small curve values.
	task automatic test_curve_and_turn_choice();
		repeat (3) send_sample(8'sd127, 8'sd0, 8'sd0);
		send_sample(8'sh80, 8'sd0, 8'sd0);
		send_sample(8'sd0, 8'sd127, -8'sd127);
		send_sample(8'sd0, 8'sh80, 8'sd127);
		send_sample(8'sd1, 8'sd0, 8'sd1);
		send_sample(-8'sd1, -8'sd1, 8'sd0);
		repeat (2) send_sample(8'sd0, 8'sd0, 8'sd0);
	endtask

	// Register extremes, masked upper data bits, zero steps and an unmapped index.
	task automatic test_register_extremes();
		set_regs(8'h7F, 8'd1, 8'hFF, 8'd1);
		send_sample(8'sd127, 8'sd127, 8'sd0);
		send_sample(-8'sd127, 8'sd0, -8'sd127);
		repeat (2) send_sample(8'sd0, 8'sd0, 8'sd0);
		send_sample(8'sd64, 8'sh80, 8'sd5);
		set_regs(8'h80, 8'h00, 8'd0, 8'd0);
		write_reg(CFG_UNMAPPED, 8'h55);
		send_sample(8'sd127, 8'sd0, 8'sd127);
		send_sample(8'sd0, 8'sd0, 8'sd0);
		send_sample(-8'sd64, 8'sd64, -8'sd64);
		set_regs(8'd1, 8'hFE, 8'd128, 8'hFF);
		send_sample(8'sd127, -8'sd127, 8'sd0);
		send_sample(8'sd0, 8'sd0, 8'sd0);
		send_sample(8'sd2, 8'sd0, -8'sd3);
	endtask

	// Held stick poses let the levels settle on their goals; jitter and noise
	// samples break up the holds.
	task automatic test_random_driving();
		logic signed [AXIS_W-1:0] f;
		logic signed [AXIS_W-1:0] l;
		logic signed [AXIS_W-1:0] r;
		int sent;
		int hold;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_regs(pick_data(1, 127), pick_data(1, 127), pick_data(0, 255), pick_data(0, 1));
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_INDEX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom_range(0, 255)));
			end
			in_gaps_on = (phase % 2) == 1;
			out_stalls_on = ((phase / 2) % 2) == 1 || phase == RANDOM_PHASES - 1;
			sent = 0;
			while (sent < SAMPLES_PER_PHASE) begin
				f = rand_axis();
				l = rand_axis();
				r = rand_axis();
				hold = $urandom_range(1, 8);
				for (int k = 0; k < hold && sent < SAMPLES_PER_PHASE; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						send_sample(AXIS_W'($urandom_range(0, 255)), AXIS_W'($urandom_range(0, 255)),
							AXIS_W'($urandom_range(0, 255)));
					end else if ($urandom_range(0, 4) == 0) begin
						send_sample(f, AXIS_W'($urandom_range(0, 255)), r);
					end else begin
						send_sample(f, l, r);
					end
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		drive_in.valid = 1'b0;
		drive_in.forward_axis = '0;
		drive_in.left_turn_axis = '0;
		drive_in.right_turn_axis = '0;
		drive_out.ready = 1'b1;
		cfg_bus.valid = 1'b0;
		cfg_bus.index = '0;
		cfg_bus.data = '0;
		shadow_cfg.rise_step = RISE_STEP_RESET;
		shadow_cfg.fall_step = FALL_STEP_RESET;
		shadow_cfg.turn_gain = TURN_GAIN_RESET;
		shadow_cfg.reverse_mix = REVERSE_MIX_RESET;
		fwd_level = '0;
		turn_level = '0;
		mismatches = 0;
		results_seen = 0;
		samples_sent = 0;
		reg_writes = 0;
		cycles = 0;
		in_gaps_on = 1'b1;
		out_stalls_on = 1'b1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_curve_and_turn_choice();
		test_register_extremes();
		test_random_driving();
		wait_drained();

		$display("Sent %0d stick samples and checked %0d drive transfers over %0d register writes,",
			samples_sent, results_seen, reg_writes);
		$display("covering step and gain extremes, zero steps, reverse mixing and idle/stall gaps.");
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
